FILE: hw/rtl/fvg_pkg.sv
// Shared constants, codes and the per-transaction record for the FAT volume geometry unit.
// No dependencies.
package fvg_pkg;

   localparam int DIV_STAGES = 32;

   localparam logic [31:0] FAT12_BOUND = 32'd4085;
   localparam logic [31:0] FAT16_BOUND = 32'd65525;

   localparam logic [1:0] KIND_FAT12 = 2'd0;
   localparam logic [1:0] KIND_FAT16 = 2'd1;
   localparam logic [1:0] KIND_FAT32 = 2'd2;

   localparam logic [27:0] LIMIT12 = 28'h0000FF0;
   localparam logic [27:0] LIMIT16 = 28'h000FFF0;
   localparam logic [27:0] LIMIT32 = 28'hFFFFFF0;

   // Byte base is sector * 0x200; a directory entry is 32 bytes.
   localparam int SECTOR_SHIFT    = 9;
   localparam int DIR_ENTRY_SHIFT = 5;

   typedef struct packed {
      logic [31:0] start;
      logic [15:0] bps;
      logic [7:0]  spc;
      logic [15:0] rsv;
      logic [7:0]  nfat;
      logic [15:0] rent;
      logic [31:0] total;
      logic [31:0] fatsec;
      logic [31:0] rclus;
      logic [39:0] fat_prod;
      logic [31:0] rsv_bytes;
      logic [23:0] cbytes;
      logic [40:0] fat_rsv;
      logic [47:0] head_lo;
      logic [24:0] head_hi;
      logic [55:0] root_rel;
      logic [63:0] head;
      logic [20:0] root_secs;
      logic [31:0] data_secs;
      logic        under;
   } fvg_rec_type;

endpackage

FILE: hw/rtl/fvg_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying a transaction record.
// Depends on fvg_pkg.
module fvg_div
   import fvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  fvg_rec_type in_rec,
   input  logic [31:0] in_num,
   input  logic [15:0] in_den,
   output logic        out_valid,
   input  logic        out_ready,
   output fvg_rec_type out_rec,
   output logic [31:0] out_quot
);

   logic [DIV_STAGES-1:0] v_ff;
   logic [15:0]           rem_ff [DIV_STAGES];
   logic [31:0]           num_ff [DIV_STAGES];
   logic [31:0]           q_ff   [DIV_STAGES];
   logic [15:0]           den_ff [DIV_STAGES];
   fvg_rec_type           rec_ff [DIV_STAGES];
   logic [15:0]           rem_in [DIV_STAGES];
   logic [31:0]           q_in   [DIV_STAGES];
   logic                  en;

   assign en       = !v_ff[DIV_STAGES-1] || out_ready;
   assign in_ready = en;

   always_comb begin
      logic [16:0] sh;
      logic [15:0] rp;
      logic [31:0] np;
      logic [31:0] qp;
      logic [15:0] dp;
      for (int i = 0; i < DIV_STAGES; i++) begin
         rp = (i == 0) ? 16'd0  : rem_ff[(i == 0) ? 0 : i-1];
         np = (i == 0) ? in_num : num_ff[(i == 0) ? 0 : i-1];
         qp = (i == 0) ? 32'd0  : q_ff[(i == 0) ? 0 : i-1];
         dp = (i == 0) ? in_den : den_ff[(i == 0) ? 0 : i-1];
         sh = {rp, np[31]};
         if (sh >= {1'b0, dp}) begin
            rem_in[i] = 16'(sh - {1'b0, dp});
            q_in[i]   = {qp[30:0], 1'b1};
         end else begin
            rem_in[i] = sh[15:0];
            q_in[i]   = {qp[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i] <= rem_in[i];
            q_ff[i]   <= q_in[i];
            if (i == 0) begin
               num_ff[i] <= {in_num[30:0], 1'b0};
               den_ff[i] <= in_den;
               rec_ff[i] <= in_rec;
            end else begin
               num_ff[i] <= {num_ff[i-1][30:0], 1'b0};
               den_ff[i] <= den_ff[i-1];
               rec_ff[i] <= rec_ff[i-1];
            end
         end
      end
   end

   // A zero divisor yields a zero quotient.
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_rec   = rec_ff[DIV_STAGES-1];
   assign out_quot  = (den_ff[DIV_STAGES-1] == 16'd0) ? 32'd0 : q_ff[DIV_STAGES-1];

endmodule

FILE: hw/rtl/fvg_front.sv
// Front pipeline: products, sector sums and the head byte offset in four stages.
// Depends on fvg_pkg.
module fvg_front
   import fvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  fvg_rec_type in_rec,
   output logic        out_valid,
   input  logic        out_ready,
   output fvg_rec_type out_rec
);

   logic [3:0]  v_ff;
   fvg_rec_type s0_ff, s1_ff, s2_ff, s3_ff;
   fvg_rec_type s0_in, s1_in, s2_in, s3_in;
   logic        en;
   logic [31:0] rel;

   assign en       = !v_ff[3] || out_ready;
   assign in_ready = en;

   always_comb begin
      s0_in = in_rec;
      s0_in.fat_prod  = 40'(in_rec.nfat) * 40'(in_rec.fatsec);
      s0_in.rsv_bytes = 32'(in_rec.rsv) * 32'(in_rec.bps);
      s0_in.cbytes    = 24'(in_rec.spc) * 24'(in_rec.bps);

      s1_in = s0_ff;
      s1_in.fat_rsv = 41'(s0_ff.fat_prod) + 41'(s0_ff.rsv);

      rel   = (s1_ff.rclus >= 32'd2) ? s1_ff.rclus - 32'd2 : 32'd0;
      s2_in = s1_ff;
      s2_in.head_lo  = 48'(s1_ff.fat_rsv[31:0]) * 48'(s1_ff.bps);
      s2_in.head_hi  = 25'(s1_ff.fat_rsv[40:32]) * 25'(s1_ff.bps);
      s2_in.root_rel = 56'(s1_ff.cbytes) * 56'(rel);

      s3_in = s2_ff;
      s3_in.head = {23'd0, s2_ff.start, 9'd0} + 64'(s2_ff.head_lo)
                 + {7'd0, s2_ff.head_hi, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_rec   = s3_ff;

endmodule

FILE: hw/rtl/fvg_back.sv
// Overhead stage: overhead sectors, underflow test and data sector count.
// Depends on fvg_pkg.
module fvg_back
   import fvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  fvg_rec_type in_rec,
   input  logic [31:0] in_root_secs,
   output logic        out_valid,
   input  logic        out_ready,
   output fvg_rec_type out_rec
);

   logic        v_ff;
   fvg_rec_type rec_ff;
   fvg_rec_type rec_in;
   logic [41:0] overhead;

   always_comb begin
      overhead = 42'(in_rec.fat_rsv) + 42'(in_root_secs);
      rec_in   = in_rec;
      rec_in.root_secs = in_root_secs[20:0];
      rec_in.under     = overhead > 42'(in_rec.total);
      rec_in.data_secs = rec_in.under ? 32'd0 : 32'(42'(in_rec.total) - overhead);
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rec_ff <= rec_in;
      end
   end

   assign out_valid = v_ff;
   assign out_rec   = rec_ff;

endmodule

FILE: hw/rtl/fat_volume_geometry_unit.sv
// Top level of the FAT volume geometry unit: front pipeline, two dividers, overhead stage, output register.
// Depends on fvg_pkg, fvg_front, fvg_div and fvg_back.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_valid/req_ready    one boot-sector record
//   rsp_     out        rsp_valid/rsp_ready    FAT type, cluster count, byte offsets
//
// A transaction enters every cycle unless a stall holds it. The path runs through four
// front stages, 32 stages of the root-directory divider, one overhead stage, 32 stages
// of the cluster divider and the output register, one quotient bit per divider stage.
// Reset is synchronous and clears only the valid bits. A stall on the response side
// holds each pipeline section whose last stage is occupied; a section whose last
// stage is empty keeps advancing, so a bubble is only squeezed out at such a boundary.
module fat_volume_geometry_unit
   import fvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_part_start_sector,
   input  logic [15:0] req_sector_bytes,
   input  logic [7:0]  req_cluster_sectors,
   input  logic [15:0] req_reserved_sectors,
   input  logic [7:0]  req_fat_copies,
   input  logic [15:0] req_root_entries,
   input  logic [15:0] req_total_sectors_short,
   input  logic [31:0] req_total_sectors_long,
   input  logic [15:0] req_fat_sectors_short,
   input  logic [31:0] req_fat_sectors_long,
   input  logic [31:0] req_root_cluster,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_fat_kind,
   output logic [27:0] rsp_cluster_limit,
   output logic [31:0] rsp_data_clusters,
   output logic [23:0] rsp_cluster_bytes,
   output logic [63:0] rsp_fat_offset,
   output logic [63:0] rsp_root_offset,
   output logic [63:0] rsp_data_offset,
   output logic        rsp_size_underflow
);

   fvg_rec_type req_rec;
   fvg_rec_type front_rec, div1_rec, back_rec, div2_rec;
   logic        front_valid, front_ready, div1_valid, div1_ready;
   logic        back_valid, back_ready, div2_valid, div2_ready;
   logic [31:0] root_num, root_secs, clusters;

   logic        out_v_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [27:0] limit_ff, limit_in;
   logic [31:0] clus_ff;
   logic [23:0] cbytes_ff;
   logic [63:0] fatoff_ff, rootoff_ff, dataoff_ff, fatoff_in, rootoff_in, dataoff_in;
   logic        under_ff;

   // The short counts win unless they are zero.
   always_comb begin
      req_rec        = '0;
      req_rec.start  = req_part_start_sector;
      req_rec.bps    = req_sector_bytes;
      req_rec.spc    = req_cluster_sectors;
      req_rec.rsv    = req_reserved_sectors;
      req_rec.nfat   = req_fat_copies;
      req_rec.rent   = req_root_entries;
      req_rec.total  = (req_total_sectors_short != 16'd0) ?
                       32'(req_total_sectors_short) : req_total_sectors_long;
      req_rec.fatsec = (req_fat_sectors_short != 16'd0) ?
                       32'(req_fat_sectors_short) : req_fat_sectors_long;
      req_rec.rclus  = req_root_cluster;
   end

   fvg_front u_front (
      .clock, .reset,
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_rec    (req_rec),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_rec   (front_rec)
   );

   // Root directory sectors, rounded up: (entries * 32 + bps - 1) / bps.
   assign root_num = {11'd0, front_rec.rent, 5'd0} + 32'(front_rec.bps) - 32'd1;

   fvg_div u_root_div (
      .clock, .reset,
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_rec    (front_rec),
      .in_num    (root_num),
      .in_den    (front_rec.bps),
      .out_valid (div1_valid),
      .out_ready (div1_ready),
      .out_rec   (div1_rec),
      .out_quot  (root_secs)
   );

   fvg_back u_back (
      .clock, .reset,
      .in_valid     (div1_valid),
      .in_ready     (div1_ready),
      .in_rec       (div1_rec),
      .in_root_secs (root_secs),
      .out_valid    (back_valid),
      .out_ready    (back_ready),
      .out_rec      (back_rec)
   );

   fvg_div u_clus_div (
      .clock, .reset,
      .in_valid  (back_valid),
      .in_ready  (back_ready),
      .in_rec    (back_rec),
      .in_num    (back_rec.data_secs),
      .in_den    (16'(back_rec.spc)),
      .out_valid (div2_valid),
      .out_ready (div2_ready),
      .out_rec   (div2_rec),
      .out_quot  (clusters)
   );

   // Type decision and the final offsets. FAT32 puts the root directory inside the
   // data area at cluster (root_cluster - 2); the older types put the fixed root
   // directory right after the FATs and the data area after it.
   always_comb begin
      if (clusters < FAT12_BOUND) begin
         kind_in  = KIND_FAT12;
         limit_in = LIMIT12;
      end else if (clusters < FAT16_BOUND) begin
         kind_in  = KIND_FAT16;
         limit_in = LIMIT16;
      end else begin
         kind_in  = KIND_FAT32;
         limit_in = LIMIT32;
      end
      fatoff_in = {23'd0, div2_rec.start, 9'd0} + 64'(div2_rec.rsv_bytes);
      if (kind_in == KIND_FAT32) begin
         dataoff_in = div2_rec.head;
         rootoff_in = div2_rec.head + 64'(div2_rec.root_rel);
      end else begin
         rootoff_in = div2_rec.head;
         dataoff_in = div2_rec.head + {43'd0, div2_rec.rent, 5'd0};
      end
   end

   assign div2_ready = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (div2_ready) begin
         out_v_ff <= div2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div2_ready) begin
         kind_ff    <= kind_in;
         limit_ff   <= limit_in;
         clus_ff    <= clusters;
         cbytes_ff  <= div2_rec.cbytes;
         fatoff_ff  <= fatoff_in;
         rootoff_ff <= rootoff_in;
         dataoff_ff <= dataoff_in;
         under_ff   <= div2_rec.under;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_fat_kind       = kind_ff;
   assign rsp_cluster_limit  = limit_ff;
   assign rsp_data_clusters  = clus_ff;
   assign rsp_cluster_bytes  = cbytes_ff;
   assign rsp_fat_offset     = fatoff_ff;
   assign rsp_root_offset    = rootoff_ff;
   assign rsp_data_offset    = dataoff_ff;
   assign rsp_size_underflow = under_ff;

endmodule

FILE: hw/rtl/fvg_checker.sv
// Port-level checks on the FAT volume geometry unit, bound to the top level.
// Depends on fvg_pkg and fat_volume_geometry_unit.
module fvg_checker
   import fvg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_fat_kind,
   input logic [27:0] rsp_cluster_limit,
   input logic [31:0] rsp_data_clusters,
   input logic        rsp_size_underflow
);

   // A stalled response transaction stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset empties the pipeline.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The end-of-chain limit follows the type.
   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fat_kind == KIND_FAT12 && rsp_cluster_limit == LIMIT12)
                 || (rsp_fat_kind == KIND_FAT16 && rsp_cluster_limit == LIMIT16)
                 || (rsp_fat_kind == KIND_FAT32 && rsp_cluster_limit == LIMIT32))
      else $error("type and limit disagree");

   // An underflowed volume has no clusters and is FAT12.
   a_under: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_underflow |->
         rsp_data_clusters == 32'd0 && rsp_fat_kind == KIND_FAT12)
      else $error("underflow with clusters");

endmodule

bind fat_volume_geometry_unit fvg_checker u_fvg_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_fat_kind       (rsp_fat_kind),
   .rsp_cluster_limit  (rsp_cluster_limit),
   .rsp_data_clusters  (rsp_data_clusters),
   .rsp_size_underflow (rsp_size_underflow)
);
